// File: hdl/adam_optimizer_step_assert.svh
// ---------------------------------------------------------------------------
// adam optimizer step assertion macros
// shared property wrappers for the adam optimizer step block
// ---------------------------------------------------------------------------
`ifndef ADAM_OPTIMIZER_STEP_ASSERT_SVH
`define ADAM_OPTIMIZER_STEP_ASSERT_SVH

// checked only outside reset
`define ADAM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ADAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/adam_pkg.sv
// ---------------------------------------------------------------------------
// adam optimizer step package
// widths, register map and constants of the adam optimizer step block
// ---------------------------------------------------------------------------
package adam_pkg;

  localparam int NUM_PARAMS = 65536;
  localparam int ADDR_W     = $clog2(NUM_PARAMS);
  localparam int IDX_W      = 16;
  localparam int VAL_W      = 32;
  localparam int NU_W       = 48;
  localparam int Q16_W      = 16;

  localparam logic [15:0] GAMMA_CUTOFF = 16'd100;
  localparam logic [15:0] BETA_CUTOFF  = 16'd1000;

  localparam logic [15:0] LR_RESET    = 16'd66;
  localparam logic [15:0] BETA_RESET  = 16'd65470;
  localparam logic [15:0] GAMMA_RESET = 16'd58982;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_LR    = 2'd0,
    REG_BETA  = 2'd1,
    REG_GAMMA = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

endpackage

// File: hdl/adam_if.sv
// ---------------------------------------------------------------------------
// adam optimizer step channels
// valid/ready interfaces for parameter items and result items
// ---------------------------------------------------------------------------
interface adam_in_if;
  logic                              valid;
  logic                              ready;
  logic        [adam_pkg::IDX_W-1:0] param_index;
  logic signed [adam_pkg::VAL_W-1:0] param_value;
  logic signed [adam_pkg::VAL_W-1:0] gradient;
  logic                              last_in_step;

  modport source (output valid, param_index, param_value, gradient, last_in_step,
                  input ready);
  modport sink   (input valid, param_index, param_value, gradient, last_in_step,
                  output ready);
endinterface

interface adam_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [adam_pkg::VAL_W-1:0] new_value;
  logic        [adam_pkg::IDX_W-1:0] out_index;
  logic                              step_done;

  modport source (output valid, new_value, out_index, step_done, input ready);
  modport sink   (input valid, new_value, out_index, step_done, output ready);
endinterface

// File: hdl/adam_optimizer_step.sv
// ---------------------------------------------------------------------------
// adam optimizer step
// per-parameter adam update with moment store and bias correction
// ---------------------------------------------------------------------------
// usage: in_ch carries one parameter item (index, value, gradient, last flag),
// out_ch returns one result item per parameter item, in order. the apb port
// writes learning rate, beta and gamma; write them while the block is idle.
// flow: after accept, the moment read-modify-write runs through S_MUL1 to
// S_MUL5 and S_WB, then a shared bit-serial unit runs three 64-step
// divisions and a 32-step square root, one bit pair or bit per cycle.
// occupancy: one item is in work at a time, taken only in S_IDLE.
// reset: the moment store is swept to zero, one entry a cycle over the
// whole store, with in_ch.ready low; config writes are taken during the sweep.
// stall: the result sits in an output register; the next item is accepted
// and worked on meanwhile, and waits at the end until the register frees.
// ---------------------------------------------------------------------------
module adam_optimizer_step (
  input  logic                         clk,
  input  logic                         rst_n,
  adam_in_if.sink                      in_ch,
  adam_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adam_pkg::PADDR_W-1:0] paddr,
  input  logic [adam_pkg::PDATA_W-1:0] pwdata,
  output logic [adam_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  `include "adam_optimizer_step_assert.svh"

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_WB,
    S_DIVM, S_DIVN, S_SQRT, S_MULD, S_MULD2, S_DIVD, S_FIN
  } state_t;

  state_t state_r;

  // memories
  logic signed [adam_pkg::VAL_W-1:0] fm_mem [adam_pkg::NUM_PARAMS];
  logic        [adam_pkg::NU_W-1:0]  sm_mem [adam_pkg::NUM_PARAMS];
  logic signed [adam_pkg::VAL_W-1:0] rd_m_r;
  logic        [adam_pkg::NU_W-1:0]  rd_nu_r;

  logic [adam_pkg::ADDR_W-1:0] clr_cnt_r;

  // config and step state
  logic [15:0] lr_r, beta_r, gamma_r;
  logic [15:0] step_r, gpow_r, bpow_r;

  // item registers
  logic [adam_pkg::IDX_W-1:0]        idx_r;
  logic signed [adam_pkg::VAL_W-1:0] val_r, grad_r;
  logic                              last_r;

  logic signed [49:0] p1_r, p2_r;
  logic signed [31:0] m_r;
  logic [46:0]        g2_r;
  logic [39:0]        q0_r, q1_r, q3_r;
  logic [40:0]        q2_r;
  logic [63:0]        bnu_r, acc_r;
  logic [47:0]        nu_r;
  logic               neg_r;
  logic [31:0]        mabs_r;
  logic [47:0]        mhat_r;
  logic [39:0]        pa_r, pb_r;

  // shared serial unit
  logic [63:0] sq_r;
  logic [34:0] rem_r;
  logic [32:0] den_r;
  logic [31:0] root_r;
  logic [5:0]  cnt_r;

  // output register
  logic                              out_valid_r;
  logic signed [adam_pkg::VAL_W-1:0] out_val_r;
  logic [adam_pkg::IDX_W-1:0]        out_idx_r;
  logic                              out_done_r;

  logic in_acc, out_load, cfg_wr;
  logic [adam_pkg::ADDR_W-1:0] slot;
  adam_pkg::reg_idx_t reg_sel;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign slot          = in_ch.param_index[adam_pkg::ADDR_W-1:0];
  assign out_load      = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign cfg_wr        = psel && penable && pwrite;
  assign pready        = 1'b1;
  assign reg_sel       = adam_pkg::reg_idx_t'(paddr[3:2]);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_value = out_val_r;
  assign out_ch.out_index = out_idx_r;
  assign out_ch.step_done = out_done_r;

  always_comb begin
    case (reg_sel)
      adam_pkg::REG_LR:    prdata = {16'h0, lr_r};
      adam_pkg::REG_BETA:  prdata = {16'h0, beta_r};
      adam_pkg::REG_GAMMA: prdata = {16'h0, gamma_r};
      default:             prdata = '0;
    endcase
  end

  // datapath terms
  logic signed [48:0] p1_w;
  logic signed [49:0] p2_w;
  logic signed [50:0] msum;
  logic signed [34:0] mshift;
  logic signed [31:0] msat;
  logic [31:0]        gabs;
  logic [63:0]        gsq, nu_full;
  logic [16:0]        omb, cg, cb;
  logic [33:0]        dsh;
  logic               dbit;
  logic [34:0]        ssh, strial;
  logic               sbit;
  logic [63:0]        dq_nxt, sq_nxt;
  logic [33:0]        drem_nxt;
  logic [34:0]        srem_nxt;
  logic [31:0]        root_nxt;
  logic [40:0]        delta;
  logic signed [42:0] nv;
  logic signed [31:0] nv_sat;

  always_comb begin
    p1_w   = $signed({1'b0, gamma_r}) * rd_m_r;
    p2_w   = $signed({1'b0, 17'h10000 - {1'b0, gamma_r}}) * grad_r;
    msum   = 51'(p1_r) + 51'(p2_r);
    mshift = 35'(msum >>> 16);
    if (mshift > 35'sd2147483647)       msat = 32'sh7fffffff;
    else if (mshift < -35'sd2147483648) msat = 32'sh80000000;
    else                                msat = mshift[31:0];
    gabs    = grad_r[31] ? 32'(-grad_r) : grad_r[31:0];
    gsq     = gabs * gabs;
    omb     = 17'h10000 - {1'b0, beta_r};
    nu_full = acc_r + {q3_r, 24'h0};
    cg      = (step_r < adam_pkg::GAMMA_CUTOFF) ? 17'h10000 - {1'b0, gpow_r} : 17'h10000;
    cb      = (step_r < adam_pkg::BETA_CUTOFF)  ? 17'h10000 - {1'b0, bpow_r} : 17'h10000;
    // restoring divide, one quotient bit a cycle
    dsh      = {rem_r[32:0], sq_r[63]};
    dbit     = dsh >= {1'b0, den_r};
    drem_nxt = dbit ? dsh - {1'b0, den_r} : dsh;
    dq_nxt   = {sq_r[62:0], dbit};
    // digit-by-digit root, two radicand bits a cycle
    ssh      = {rem_r[32:0], sq_r[63:62]};
    strial   = {1'b0, root_r, 2'b01};
    sbit     = ssh >= strial;
    srem_nxt = sbit ? ssh - strial : ssh;
    root_nxt = {root_r[30:0], sbit};
    sq_nxt   = {sq_r[61:0], 2'b00};
    delta  = (sq_r > 64'h100_0000_0000) ? 41'h100_0000_0000 : sq_r[40:0];
    nv     = neg_r ? 43'(val_r) + $signed({2'b0, delta}) : 43'(val_r) - $signed({2'b0, delta});
    if (nv > 43'sd2147483647)       nv_sat = 32'sh7fffffff;
    else if (nv < -43'sd2147483648) nv_sat = 32'sh80000000;
    else                            nv_sat = nv[31:0];
  end

  // moment store
  logic                        mem_we;
  logic [adam_pkg::ADDR_W-1:0] mem_wa;
  assign mem_we = (state_r == S_CLEAR) || (state_r == S_WB);
  assign mem_wa = (state_r == S_CLEAR) ? clr_cnt_r : idx_r[adam_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fm_mem[mem_wa] <= (state_r == S_CLEAR) ? '0 : m_r;
      sm_mem[mem_wa] <= (state_r == S_CLEAR) ? '0 : nu_r;
    end
    if (in_acc) begin
      rd_m_r  <= fm_mem[slot];
      rd_nu_r <= sm_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      lr_r        <= adam_pkg::LR_RESET;
      beta_r      <= adam_pkg::BETA_RESET;
      gamma_r     <= adam_pkg::GAMMA_RESET;
      step_r      <= 16'd1;
      gpow_r      <= adam_pkg::GAMMA_RESET;
      bpow_r      <= adam_pkg::BETA_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_sel)
          adam_pkg::REG_LR:    lr_r <= pwdata[15:0];
          adam_pkg::REG_BETA:  begin beta_r <= pwdata[15:0];  bpow_r <= pwdata[15:0]; end
          adam_pkg::REG_GAMMA: begin gamma_r <= pwdata[15:0]; gpow_r <= pwdata[15:0]; end
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready && !out_load) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == adam_pkg::ADDR_W'(adam_pkg::NUM_PARAMS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            idx_r   <= in_ch.param_index;
            val_r   <= in_ch.param_value;
            grad_r  <= in_ch.gradient;
            last_r  <= in_ch.last_in_step;
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1_r    <= 50'(p1_w);
          p2_r    <= p2_w;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          m_r     <= msat;
          g2_r    <= gsq[62:16];
          q0_r    <= beta_r * rd_nu_r[23:0];
          q1_r    <= beta_r * rd_nu_r[47:24];
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          bnu_r   <= 64'(q0_r) + {q1_r, 24'h0};
          q2_r    <= omb * g2_r[23:0];
          q3_r    <= omb * g2_r[46:24];
          neg_r   <= m_r[31];
          mabs_r  <= m_r[31] ? 32'(-m_r) : m_r[31:0];
          state_r <= S_MUL4;
        end
        S_MUL4: begin
          acc_r   <= bnu_r + 64'(q2_r);
          state_r <= S_MUL5;
        end
        S_MUL5: begin
          nu_r    <= nu_full[63:16];
          state_r <= S_WB;
        end
        S_WB: begin
          sq_r    <= {16'h0, mabs_r, 16'h0};
          den_r   <= 33'(cg);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIVM;
        end
        S_DIVM: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) begin
            mhat_r  <= dq_nxt[47:0];
            sq_r    <= {nu_r, 16'h0};
            den_r   <= 33'(cb);
            rem_r   <= '0;
            state_r <= S_DIVN;
          end else begin
            sq_r  <= dq_nxt;
            rem_r <= 35'(drem_nxt);
          end
        end
        S_DIVN: begin
          sq_r  <= dq_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) begin
            rem_r   <= '0;
            root_r  <= '0;
            state_r <= S_SQRT;
          end else begin
            rem_r <= 35'(drem_nxt);
          end
        end
        S_SQRT: begin
          sq_r   <= sq_nxt;
          rem_r  <= srem_nxt;
          root_r <= root_nxt;
          if (cnt_r == 6'd31) begin
            den_r   <= 33'(root_nxt) + 33'd1;
            cnt_r   <= '0;
            state_r <= S_MULD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MULD: begin
          pa_r    <= lr_r * mhat_r[23:0];
          pb_r    <= lr_r * mhat_r[47:24];
          state_r <= S_MULD2;
        end
        S_MULD2: begin
          sq_r    <= 64'(pa_r) + {pb_r, 24'h0};
          rem_r   <= '0;
          state_r <= S_DIVD;
        end
        S_DIVD: begin
          sq_r  <= dq_nxt;
          rem_r <= 35'(drem_nxt);
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_val_r   <= nv_sat;
            out_idx_r   <= idx_r;
            out_done_r  <= last_r;
            if (last_r) begin
              if (step_r != 16'hffff) step_r <= step_r + 16'd1;
              gpow_r <= 16'((32'(gpow_r) * 32'(gamma_r)) >> 16);
              bpow_r <= 16'((32'(bpow_r) * 32'(beta_r)) >> 16);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ADAM_ASSERT(a_no_accept_clear, clk, rst_n,
               (state_r == S_CLEAR) |-> !in_ch.ready, "item accepted during store sweep")
  `ADAM_ASSERT(a_load_valid, clk, rst_n,
               out_load |=> (out_valid_r && out_idx_r == $past(idx_r)), "result not loaded")
  `ADAM_ASSERT(a_step_nonzero, clk, rst_n,
               step_r != 16'd0, "step counter reached zero")
  `ADAM_ASSERT(a_wb_after_mul, clk, rst_n,
               (state_r == S_WB) |-> ($past(state_r) == S_MUL5), "moment write out of order")

endmodule
